/* hdl/ued_pkg.sv */
// ----------------------------------------------------------------------------
// ued_pkg
// Types, codes and helpers shared by the unicode escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ued_pkg;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_LOWER_U   = 8'h75;
  localparam logic [7:0] CHAR_UPPER_U   = 8'h55;

  localparam logic [3:0] DIGITS_SHORT = 4'd4;
  localparam logic [3:0] DIGITS_LONG  = 4'd8;

  localparam logic [3:0] USED_SHORT = 4'd6;
  localparam logic [3:0] USED_LONG  = 4'd10;
  localparam logic [3:0] USED_PAIR  = 4'd12;

  localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
  localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_END = 16'hE000;
  localparam logic [31:0] PLANE1_BASE  = 32'h0001_0000;

  typedef enum logic [3:0] {
    PH_START = 4'd0,
    PH_KIND  = 4'd1,
    PH_HEX1  = 4'd2,
    PH_BSL2  = 4'd3,
    PH_U2    = 4'd4,
    PH_HEX2  = 4'd5,
    PH_SKIP  = 4'd6
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_NO_BSL   = 4'd1,
    ST_BAD_KIND = 4'd2,
    ST_BAD_HEX  = 4'd3,
    ST_LONE_LOW = 4'd4,
    ST_NO_BSL2  = 4'd5,
    ST_NO_U2    = 4'd6,
    ST_BAD_LOW  = 4'd7,
    ST_TRUNC    = 4'd8
  } status_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
  } char_beat_t;

  typedef struct packed {
    logic [31:0] code_point;
    logic [3:0]  chars_used;
    status_t     status;
  } res_beat_t;

  // bit 4 flags a valid hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/unicode_escape_decoder_unit.sv */
// the escape's last beat registers its result on res_beat, or in the skid entry under stall
// throughput: one character beat per cycle while the two-entry output skid is not full;
// the decode is a single step of the phase register and nibble shift
// reset: synchronous rst returns to the first-backslash phase with empty output
// ----------------------------------------------------------------------------
// unicode_escape_decoder_unit
// Decodes a leading \uXXXX, \UXXXXXXXX or surrogate pair escape from a
// character stream and reports code point, length and status.
// ----------------------------------------------------------------------------
`default_nettype none

module unicode_escape_decoder_unit
  import ued_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        char_valid,
  output logic       char_stall,
  input  char_beat_t char_beat,
  output logic       res_valid,
  input  wire        res_stall,
  output res_beat_t  res_beat
);

  phase_t      phase, phase_next;
  logic [3:0]  digits_left, digits_left_next;
  logic [31:0] accumulator, accumulator_next;
  logic [15:0] high_unit, high_unit_next;
  logic [3:0]  count_used, count_used_next;

  logic        skid_valid;
  res_beat_t   skid_beat;

  logic        take;
  logic        emit;
  res_beat_t   emit_beat;

  logic [4:0]  hex;
  logic [3:0]  cnt_inc;
  logic [3:0]  dl_dec;
  logic [31:0] acc_sh;
  logic [15:0] acc16;
  logic        last;

  assign take       = char_valid && !char_stall;
  assign char_stall = skid_valid;
  assign last       = char_beat.last_char;
  assign hex        = hex_decode(char_beat.char_byte);
  assign cnt_inc    = count_used + 4'd1;
  assign dl_dec     = digits_left - 4'd1;
  assign acc_sh     = {accumulator[27:0], hex[3:0]};
  assign acc16      = acc_sh[15:0];

  always_comb begin
    phase_next       = phase;
    digits_left_next = digits_left;
    accumulator_next = accumulator;
    high_unit_next   = high_unit;
    count_used_next  = cnt_inc;
    emit             = 1'b0;
    emit_beat        = '{code_point: 32'd0, chars_used: 4'd0, status: ST_TRUNC};

    unique case (phase)
      PH_SKIP: begin
        count_used_next = count_used;
        if (last) begin
          phase_next = PH_START;
        end
      end
      PH_START: begin
        if (char_beat.char_byte != CHAR_BACKSLASH) begin
          emit             = 1'b1;
          emit_beat.status = ST_NO_BSL;
        end else begin
          phase_next = PH_KIND;
        end
      end
      PH_KIND: begin
        if (char_beat.char_byte == CHAR_UPPER_U) begin
          digits_left_next = DIGITS_LONG;
          accumulator_next = 32'd0;
          phase_next       = PH_HEX1;
        end else if (char_beat.char_byte == CHAR_LOWER_U) begin
          digits_left_next = DIGITS_SHORT;
          accumulator_next = 32'd0;
          phase_next       = PH_HEX1;
        end else begin
          emit             = 1'b1;
          emit_beat.status = ST_BAD_KIND;
        end
      end
      PH_HEX1: begin
        if (!hex[4]) begin
          emit             = 1'b1;
          emit_beat.status = ST_BAD_HEX;
        end else begin
          accumulator_next = acc_sh;
          digits_left_next = dl_dec;
          if (dl_dec == 4'd0) begin
            if (cnt_inc == USED_LONG) begin
              emit      = 1'b1;
              emit_beat = '{code_point: acc_sh, chars_used: USED_LONG, status: ST_OK};
            end else if (acc16 >= LOW_SURR_LO && acc16 < LOW_SURR_END) begin
              emit             = 1'b1;
              emit_beat.status = ST_LONE_LOW;
            end else if (acc16 >= HIGH_SURR_LO && acc16 < LOW_SURR_LO) begin
              // high surrogate, wait for the second half
              high_unit_next   = acc16;
              accumulator_next = 32'd0;
              phase_next       = PH_BSL2;
            end else begin
              emit      = 1'b1;
              emit_beat = '{code_point: {16'd0, acc16}, chars_used: USED_SHORT,
                            status: ST_OK};
            end
          end
        end
      end
      PH_BSL2: begin
        if (char_beat.char_byte != CHAR_BACKSLASH) begin
          emit             = 1'b1;
          emit_beat.status = ST_NO_BSL2;
        end else begin
          phase_next = PH_U2;
        end
      end
      PH_U2: begin
        if (char_beat.char_byte != CHAR_LOWER_U) begin
          emit             = 1'b1;
          emit_beat.status = ST_NO_U2;
        end else begin
          digits_left_next = DIGITS_SHORT;
          accumulator_next = 32'd0;
          phase_next       = PH_HEX2;
        end
      end
      PH_HEX2: begin
        if (!hex[4]) begin
          emit             = 1'b1;
          emit_beat.status = ST_BAD_HEX;
        end else begin
          accumulator_next = {16'd0, acc16};
          digits_left_next = dl_dec;
          if (dl_dec == 4'd0) begin
            emit = 1'b1;
            if (acc16 < LOW_SURR_LO || acc16 >= LOW_SURR_END) begin
              emit_beat.status = ST_BAD_LOW;
            end else begin
              emit_beat = '{code_point: PLANE1_BASE + {12'd0, high_unit[9:0], acc16[9:0]},
                            chars_used: USED_PAIR, status: ST_OK};
            end
          end
        end
      end
      default: begin
        count_used_next  = 4'd0;
        digits_left_next = 4'd0;
        accumulator_next = 32'd0;
        high_unit_next   = 16'd0;
        phase_next       = PH_START;
      end
    endcase

    // string ended before the escape finished
    if (!emit && last && phase != PH_SKIP && phase_next != PH_START) begin
      emit             = 1'b1;
      emit_beat.status = ST_TRUNC;
    end

    if (emit) begin
      digits_left_next = 4'd0;
      accumulator_next = 32'd0;
      high_unit_next   = 16'd0;
      count_used_next  = 4'd0;
      phase_next       = last ? PH_START : PH_SKIP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      digits_left <= 4'd0;
      accumulator <= 32'd0;
      high_unit   <= 16'd0;
      count_used  <= 4'd0;
    end else if (take) begin
      phase       <= phase_next;
      digits_left <= digits_left_next;
      accumulator <= accumulator_next;
      high_unit   <= high_unit_next;
      count_used  <= count_used_next;
    end
  end

  // output register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!res_valid || !res_stall) begin
        if (skid_valid) begin
          res_valid  <= 1'b1;
          res_beat   <= skid_beat;
          skid_valid <= 1'b0;
        end else begin
          res_valid <= take && emit;
          if (take && emit) begin
            res_beat <= emit_beat;
          end
        end
      end else if (take && emit) begin
        skid_valid <= 1'b1;
        skid_beat  <= emit_beat;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry held while output register empty");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_beat.status != ST_OK) |->
      (res_beat.code_point == 32'd0 && res_beat.chars_used == 4'd0))
    else $error("error beat carries code point or length");

  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_beat.status == ST_OK) |->
      (res_beat.chars_used == USED_SHORT || res_beat.chars_used == USED_LONG ||
       res_beat.chars_used == USED_PAIR))
    else $error("ok beat with odd length");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (take && emit && res_valid && res_stall && !skid_valid) |=> skid_valid)
    else $error("result lost under output stall");
`endif

endmodule

`default_nettype wire
